// ----- hw/rtl/oaht_pkg.sv -----
// Shared types, constants and a helper function for the open-address hash table.
`default_nettype none

package oaht_pkg;

    // Table geometry.
    localparam int MAX_SLOTS = 4096;
    localparam int SLOT_AW   = $clog2(MAX_SLOTS);
    localparam int SIZE_W    = SLOT_AW + 1;
    localparam int MIN_SLOTS = 13;

    // Field widths fixed by the interface.
    localparam int KEY_W     = 31;
    localparam int PAYLOAD_W = 32;
    localparam int CNT_W     = 13;

    // Remainder unit: two dividend bits per cycle over a 32-bit dividend.
    localparam int DVD_W     = 32;
    localparam int DIV_STEPS = DVD_W / 2;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // One-step FNV-1a constants.
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // Command codes.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // Status codes.
    localparam logic [2:0] STAT_INSERTED    = 3'd0;
    localparam logic [2:0] STAT_DUPLICATE   = 3'd1;
    localparam logic [2:0] STAT_FULL        = 3'd2;
    localparam logic [2:0] STAT_FOUND       = 3'd3;
    localparam logic [2:0] STAT_ABSENT      = 3'd4;
    localparam logic [2:0] STAT_REMOVED     = 3'd5;
    localparam logic [2:0] STAT_REMOVE_MISS = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] REG_HASH_SELECT = 3'd0;
    localparam logic [2:0] REG_PROBE_MODE  = 3'd1;
    localparam logic [2:0] REG_COEF_ONE    = 3'd2;
    localparam logic [2:0] REG_COEF_TWO    = 3'd3;
    localparam logic [2:0] REG_TABLE_SIZE  = 3'd4;

    typedef struct packed {
        logic [1:0]                  command;
        logic [KEY_W-1:0]            key;
        logic signed [PAYLOAD_W-1:0] payload;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0] probe_count;
        logic [2:0]       status;
        logic [31:0]      collision_total;
        logic [CNT_W-1:0] live_entries;
    } rsp_t;

    typedef struct packed {
        logic used;
        logic tomb;
    } flags_t;

    // One write to the slot memories.
    typedef struct packed {
        logic [SLOT_AW-1:0]    addr;
        logic                  flag_we;
        flags_t                flags;
        logic                  data_we;
        logic [KEY_W-1:0]      key;
        logic [PAYLOAD_W-1:0]  payload;
    } mem_wr_t;

    // Sum of two residues, reduced once by the modulus.
    function automatic logic [SIZE_W-1:0] mod_add(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b,
                                                  input logic [SIZE_W-1:0] m);
        logic [SIZE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, m})
        begin
            sum = sum - {1'b0, m};
        end
        return sum[SIZE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/oaht_rem.sv -----
// Iterative remainder unit: 32-bit dividend by a table-sized divisor, two bits a cycle.
`default_nettype none

module oaht_rem (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      load,
    input  wire logic [oaht_pkg::DVD_W-1:0]  dividend,
    input  wire logic [oaht_pkg::SIZE_W-1:0] divisor,
    output logic                           done,
    output logic [oaht_pkg::SIZE_W-1:0]    remainder
);
    import oaht_pkg::*;

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_CW-1:0]    cnt_reg, cnt_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [SIZE_W-1:0]    rem_reg, rem_next;
    logic [SIZE_W-1:0]    dvs_reg, dvs_next;
    logic [SIZE_W:0]      trial_a;
    logic [SIZE_W:0]      trial_b;
    logic [SIZE_W-1:0]    rem_a;
    logic [SIZE_W-1:0]    rem_b;

    // Two restoring steps per cycle.
    always_comb
    begin
        trial_a = {rem_reg, quo_reg[DVD_W-1]};
        if (trial_a >= {1'b0, dvs_reg})
        begin
            trial_a = trial_a - {1'b0, dvs_reg};
        end
        rem_a   = trial_a[SIZE_W-1:0];
        trial_b = {rem_a, quo_reg[DVD_W-2]};
        if (trial_b >= {1'b0, dvs_reg})
        begin
            trial_b = trial_b - {1'b0, dvs_reg};
        end
        rem_b   = trial_b[SIZE_W-1:0];
    end

    // Sequencing of the iterations.
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (load)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[DVD_W-3:0], 2'b00};
            rem_next = rem_b;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/oaht_slot_mem.sv -----
// Slot storage: a flag memory (used, tombstone) and a key and payload memory.
`default_nettype none

module oaht_slot_mem (
    input  wire logic                         clk,
    input  wire logic [oaht_pkg::SLOT_AW-1:0] rd_addr,
    input  wire oaht_pkg::mem_wr_t            wr,
    output oaht_pkg::flags_t                  rd_flags,
    output logic [oaht_pkg::KEY_W-1:0]        rd_key
);
    import oaht_pkg::*;

    flags_t               flag_mem [MAX_SLOTS];
    logic [KEY_W-1:0]     key_mem [MAX_SLOTS];
    logic [PAYLOAD_W-1:0] payload_mem [MAX_SLOTS];
    flags_t               flags_q;
    logic [KEY_W-1:0]     key_q;

    // Flag memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr.flag_we)
        begin
            flag_mem[wr.addr] <= wr.flags;
        end
        flags_q <= flag_mem[rd_addr];
    end

    // Key and payload memories; the payload is kept with its key.
    always_ff @(posedge clk)
    begin
        if (wr.data_we)
        begin
            key_mem[wr.addr]     <= wr.key;
            payload_mem[wr.addr] <= wr.payload;
        end
        key_q <= key_mem[rd_addr];
    end

    assign rd_flags = flags_q;
    assign rd_key   = key_q;

endmodule

`default_nettype wire

// ----- hw/rtl/open_address_hash_table.sv -----
// Top level: open-addressing hash table with double hashing or quadratic probing.
//
//  Channel   Signals                              Direction  Beat taken when
//  command   start, busy, request                 in         start && !busy
//  result    result_valid, result                 out        result_valid (one cycle)
//  config    psel penable pwrite paddr pwdata     in         psel && penable && pwrite
//            prdata pready                        out
//
// After reset the flag memory is cleared, one slot a cycle, over all 4096 slots, busy high.
// A command passes the FNV multiply state, then the remainder units for the home slot and
// step, then in quadratic mode the remainder units again for the probe increments, then
// issues one probe per cycle, one flag and key memory read each, read through a register.
// The result strobe follows the last probe; busy falls in the same cycle. Results cannot
// be held off. Write configuration only while busy is low; the block does not enforce it.
`default_nettype none

module open_address_hash_table (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire oaht_pkg::req_t request,
    output logic                result_valid,
    output oaht_pkg::rsp_t      result,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [4:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import oaht_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MULT  = 6'b000100,
        S_DIV1  = 6'b001000,
        S_DIV2  = 6'b010000,
        S_PROBE = 6'b100000
    } state_t;

    state_t              state_reg, state_next;

    // Configuration registers.
    logic                hash_select_reg;
    logic                probe_mode_reg;
    logic [15:0]         coef_one_reg;
    logic [15:0]         coef_two_reg;
    logic [12:0]         table_size_reg;
    logic                cfg_we;

    // Command context.
    req_t                req_reg, req_next;
    logic [SIZE_W-1:0]   s_reg, s_next;
    logic [SIZE_W-1:0]   idx_reg, idx_next;
    logic [SIZE_W-1:0]   d_reg, d_next;
    logic [SIZE_W-1:0]   dd_reg, dd_next;
    logic [SIZE_W-1:0]   icnt_reg, icnt_next;
    logic                rdv_reg, rdv_next;
    logic [SIZE_W-1:0]   paddr_reg, paddr_next;
    logic [SIZE_W-1:0]   pnum_reg, pnum_next;
    logic [SLOT_AW-1:0]  clr_reg, clr_next;

    // Running counters and the result register.
    logic [SIZE_W-1:0]   live_reg, live_next;
    logic [31:0]         coll_reg, coll_next;
    rsp_t                rsp_reg, rsp_next;
    logic                strobe_reg, strobe_next;

    // Datapath signals.
    logic [SIZE_W-1:0]   eff_size;
    logic [31:0]         fnv_prod;
    logic [SIZE_W-1:0]   step;
    logic [28:0]         quad_prod;
    logic                load;
    logic [DVD_W-1:0]    dvd_a, dvd_b;
    logic [SIZE_W-1:0]   dvs_a, dvs_b;
    logic                done_a, done_b;
    logic [SIZE_W-1:0]   rem_a, rem_b;
    mem_wr_t             mem_wr;
    flags_t              rd_flags;
    logic [KEY_W-1:0]    rd_key;
    logic                key_match;
    logic                stop;
    logic [2:0]          stat;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_select_reg <= 1'b0;
            probe_mode_reg  <= 1'b0;
            coef_one_reg    <= 16'd1;
            coef_two_reg    <= 16'd1;
            table_size_reg  <= 13'd13;
        end
        else if (cfg_we)
        begin
            case (paddr[4:2])
                REG_HASH_SELECT: hash_select_reg <= pwdata[0];
                REG_PROBE_MODE:  probe_mode_reg  <= pwdata[0];
                REG_COEF_ONE:    coef_one_reg    <= pwdata[15:0];
                REG_COEF_TWO:    coef_two_reg    <= pwdata[15:0];
                REG_TABLE_SIZE:  table_size_reg  <= pwdata[12:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_HASH_SELECT: prdata = {31'd0, hash_select_reg};
            REG_PROBE_MODE:  prdata = {31'd0, probe_mode_reg};
            REG_COEF_ONE:    prdata = {16'd0, coef_one_reg};
            REG_COEF_TWO:    prdata = {16'd0, coef_two_reg};
            REG_TABLE_SIZE:  prdata = {19'd0, table_size_reg};
            default:         prdata = '0;
        endcase
    end

    // Effective table size, clamped to the supported range.
    always_comb
    begin
        if (table_size_reg < 13'(MIN_SLOTS))
        begin
            eff_size = SIZE_W'(MIN_SLOTS);
        end
        else if ({1'b0, table_size_reg} > 14'(MAX_SLOTS))
        begin
            eff_size = SIZE_W'(MAX_SLOTS);
        end
        else
        begin
            eff_size = SIZE_W'(table_size_reg);
        end
    end

    // Hash multiply and probe increment multiply; each feeds a divider register.
    assign fnv_prod  = (FNV_BASIS ^ {1'b0, req_reg.key}) * FNV_PRIME;
    assign step      = rem_b + 1'b1;
    assign quad_prod = coef_one_reg * step;

    oaht_rem u_rem_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .dividend  (dvd_a),
        .divisor   (dvs_a),
        .done      (done_a),
        .remainder (rem_a)
    );

    oaht_rem u_rem_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .dividend  (dvd_b),
        .divisor   (dvs_b),
        .done      (done_b),
        .remainder (rem_b)
    );

    oaht_slot_mem u_mem (
        .clk      (clk),
        .rd_addr  (idx_reg[SLOT_AW-1:0]),
        .wr       (mem_wr),
        .rd_flags (rd_flags),
        .rd_key   (rd_key)
    );

    assign key_match = (rd_key == req_reg.key);

    // Probe decision for the slot whose read data has just arrived.
    always_comb
    begin
        stop = 1'b0;
        case (req_reg.command)
            CMD_INSERT:
            begin
                stat = STAT_FULL;
                if (!rd_flags.used || rd_flags.tomb)
                begin
                    stop = 1'b1;
                    stat = STAT_INSERTED;
                end
                else if (key_match)
                begin
                    stop = 1'b1;
                    stat = STAT_DUPLICATE;
                end
            end
            CMD_REMOVE:
            begin
                stat = STAT_REMOVE_MISS;
                if (!rd_flags.used)
                begin
                    stop = 1'b1;
                end
                else if (!rd_flags.tomb && key_match)
                begin
                    stop = 1'b1;
                    stat = STAT_REMOVED;
                end
            end
            default:
            begin
                stat = STAT_ABSENT;
                if (!rd_flags.used && !rd_flags.tomb)
                begin
                    stop = 1'b1;
                end
                else if (rd_flags.used && !rd_flags.tomb && key_match)
                begin
                    stop = 1'b1;
                    stat = STAT_FOUND;
                end
            end
        endcase
        if (pnum_reg == s_reg)
        begin
            stop = 1'b1;
        end
    end

    // Command sequencer.
    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        s_next      = s_reg;
        idx_next    = idx_reg;
        d_next      = d_reg;
        dd_next     = dd_reg;
        icnt_next   = icnt_reg;
        rdv_next    = rdv_reg;
        paddr_next  = paddr_reg;
        pnum_next   = pnum_reg;
        clr_next    = clr_reg;
        live_next   = live_reg;
        coll_next   = coll_reg;
        rsp_next    = rsp_reg;
        strobe_next = 1'b0;
        load        = 1'b0;
        dvd_a       = '0;
        dvd_b       = '0;
        dvs_a       = s_reg;
        dvs_b       = s_reg;
        mem_wr      = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_wr.addr    = clr_reg;
                mem_wr.flag_we = 1'b1;
                clr_next       = clr_reg + 1'b1;
                if (clr_reg == SLOT_AW'(MAX_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    s_next     = eff_size;
                    state_next = S_MULT;
                end
            end
            S_MULT:
            begin
                // Home slot dividend and step dividend.
                load       = 1'b1;
                dvd_a      = hash_select_reg ? fnv_prod : {1'b0, req_reg.key};
                dvd_b      = {1'b0, req_reg.key};
                dvs_b      = s_reg - 1'b1;
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                if (done_a && done_b)
                begin
                    idx_next  = rem_a;
                    icnt_next = '0;
                    rdv_next  = 1'b0;
                    pnum_next = '0;
                    if (probe_mode_reg)
                    begin
                        // First increment c1*step + c2 and its growth 2*c2, mod size.
                        load       = 1'b1;
                        dvd_a      = DVD_W'(quad_prod) + DVD_W'(coef_two_reg);
                        dvd_b      = DVD_W'({coef_two_reg, 1'b0});
                        state_next = S_DIV2;
                    end
                    else
                    begin
                        d_next     = step;
                        dd_next    = '0;
                        state_next = S_PROBE;
                    end
                end
            end
            S_DIV2:
            begin
                if (done_a && done_b)
                begin
                    d_next     = rem_a;
                    dd_next    = rem_b;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                // Issue the next probe address while the previous read returns.
                if (icnt_reg < s_reg)
                begin
                    rdv_next   = 1'b1;
                    paddr_next = idx_reg;
                    pnum_next  = icnt_reg + 1'b1;
                    icnt_next  = icnt_reg + 1'b1;
                    idx_next   = mod_add(idx_reg, d_reg, s_reg);
                    d_next     = mod_add(d_reg, dd_reg, s_reg);
                end
                else
                begin
                    rdv_next = 1'b0;
                end
                if (rdv_reg && stop)
                begin
                    mem_wr.addr    = paddr_reg[SLOT_AW-1:0];
                    mem_wr.key     = req_reg.key;
                    mem_wr.payload = req_reg.payload;
                    if (stat == STAT_INSERTED)
                    begin
                        mem_wr.flag_we    = 1'b1;
                        mem_wr.flags.used = 1'b1;
                        mem_wr.data_we    = 1'b1;
                        live_next         = live_reg + 1'b1;
                        if (pnum_reg != SIZE_W'(1))
                        begin
                            coll_next = coll_reg + 1'b1;
                        end
                    end
                    else if (stat == STAT_REMOVED)
                    begin
                        mem_wr.flag_we    = 1'b1;
                        mem_wr.flags.used = 1'b1;
                        mem_wr.flags.tomb = 1'b1;
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - 1'b1;
                        end
                    end
                    rsp_next.probe_count     = CNT_W'(pnum_reg);
                    rsp_next.status          = stat;
                    rsp_next.collision_total = coll_next;
                    rsp_next.live_entries    = CNT_W'(live_next);
                    strobe_next              = 1'b1;
                    rdv_next                 = 1'b0;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            rdv_reg    <= 1'b0;
            icnt_reg   <= '0;
            live_reg   <= '0;
            coll_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            rdv_reg    <= rdv_next;
            icnt_reg   <= icnt_next;
            live_reg   <= live_next;
            coll_reg   <= coll_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        s_reg     <= s_next;
        idx_reg   <= idx_next;
        d_reg     <= d_next;
        dd_reg    <= dd_next;
        paddr_reg <= paddr_next;
        pnum_reg  <= pnum_next;
        rsp_reg   <= rsp_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = strobe_reg;
    assign result       = rsp_reg;

endmodule

`default_nettype wire

// ----- tb/tb_open_address_hash_table.sv -----
// Self-checking testbench for the open-address hash table: directed rows, then random phases.
`default_nettype none

module tb_open_address_hash_table;
    import oaht_pkg::*;

    // The unnamed fourth command code behaves as a search.
    localparam logic [1:0] CMD_ALT_SEARCH = 2'd3;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    req_t        request = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        busy;
    logic        result_valid;
    rsp_t        result;
    logic [31:0] prdata;
    logic        pready;

    open_address_hash_table u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .result_valid(result_valid), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copy of the configuration and the table contents.
    logic        hash_sel = 1'b0;
    logic        quad_mode = 1'b0;
    logic [15:0] coef_lin = 16'd1;
    logic [15:0] coef_sq = 16'd1;
    logic [12:0] size_reg = 13'd13;
    logic [KEY_W-1:0]     slot_k [MAX_SLOTS];
    logic [PAYLOAD_W-1:0] slot_p [MAX_SLOTS];
    bit          slot_used [MAX_SLOTS];
    bit          slot_tomb [MAX_SLOTS];
    logic [12:0] live_cnt = '0;
    logic [31:0] coll_cnt = '0;

    rsp_t        pending_rsp [$];
    int          errors = 0;
    int          idle_cycles = 0;
    logic [KEY_W-1:0] key_pool [16];

    typedef struct {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
        logic [31:0]      pay;
        bit               typed;
        rsp_t             rsp;
    } dir_row_t;

    typedef struct {
        logic        hs;
        logic        pm;
        logic [15:0] c1;
        logic [15:0] c2;
        logic [12:0] size;
        int          count;
    } phase_t;

    dir_row_t dir_rows [23];
    phase_t   phases [13];

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Runs one command against the shadow table and returns its result.
    function automatic rsp_t table_step(req_t r);
        int unsigned s;
        int unsigned home;
        int unsigned stp;
        int unsigned idx;
        int unsigned probes;
        logic [2:0]  st;
        logic [31:0] fnv;
        longint unsigned v;
        rsp_t        o;
        s = size_reg;
        if (s < MIN_SLOTS) s = MIN_SLOTS;
        if (s > MAX_SLOTS) s = MAX_SLOTS;
        if (hash_sel)
        begin
            fnv = (FNV_BASIS ^ {1'b0, r.key}) * FNV_PRIME;
            home = fnv % s;
        end
        else
        begin
            home = r.key % s;
        end
        stp = (r.key % (s - 1)) + 1;
        probes = s;
        if (r.command == CMD_INSERT) st = STAT_FULL;
        else if (r.command == CMD_REMOVE) st = STAT_REMOVE_MISS;
        else st = STAT_ABSENT;
        for (int unsigned i = 0; i < s; i++)
        begin
            if (quad_mode)
                v = longint'(home) + longint'(coef_lin) * i * stp + longint'(coef_sq) * i * i;
            else
                v = longint'(home) + longint'(i) * stp;
            idx = v % s;
            if (r.command == CMD_INSERT)
            begin
                if (!slot_used[idx] || slot_tomb[idx])
                begin
                    if (i > 0) coll_cnt++;
                    slot_k[idx] = r.key;
                    slot_p[idx] = r.payload;
                    slot_used[idx] = 1'b1;
                    slot_tomb[idx] = 1'b0;
                    live_cnt++;
                    st = STAT_INSERTED;
                    probes = i + 1;
                    break;
                end
                if (slot_k[idx] == r.key)
                begin
                    st = STAT_DUPLICATE;
                    probes = i + 1;
                    break;
                end
            end
            else if (r.command == CMD_REMOVE)
            begin
                if (!slot_used[idx])
                begin
                    probes = i + 1;
                    break;
                end
                if (!slot_tomb[idx] && slot_k[idx] == r.key)
                begin
                    slot_tomb[idx] = 1'b1;
                    if (live_cnt > 0) live_cnt--;
                    st = STAT_REMOVED;
                    probes = i + 1;
                    break;
                end
            end
            else
            begin
                if (!slot_used[idx] && !slot_tomb[idx])
                begin
                    probes = i + 1;
                    break;
                end
                if (slot_used[idx] && !slot_tomb[idx] && slot_k[idx] == r.key)
                begin
                    st = STAT_FOUND;
                    probes = i + 1;
                    break;
                end
            end
        end
        o.probe_count = probes[12:0];
        o.status = st;
        o.collision_total = coll_cnt;
        o.live_entries = live_cnt;
        return o;
    endfunction

    // Sends one command beat after a random gap and records what it must return.
    task automatic send_cmd(req_t r, bit typed, rsp_t typed_rsp);
        int gap;
        int pick;
        rsp_t pred;
        pick = $urandom_range(0, 99);
        if (pick < 55) gap = 0;
        else if (pick < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 60);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // Now and then hold off until the table has answered everything.
        if (pick == 99)
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pending_rsp.size() != 0) @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
        pred = table_step(r);
        pending_rsp = {pending_rsp, (typed ? typed_rsp : pred)};
    endtask

    // Waits until the block is idle and then writes one register.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0 || busy) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HASH_SELECT: hash_sel = value[0];
            REG_PROBE_MODE:  quad_mode = value[0];
            REG_COEF_ONE:    coef_lin = value[15:0];
            REG_COEF_TWO:    coef_sq = value[15:0];
            REG_TABLE_SIZE:  size_reg = value[12:0];
            default: ;
        endcase
    endtask

    task automatic report(string name, longint unsigned want, longint unsigned got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    // Each result beat is compared with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_rsp.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, status %0d", $time, result.status);
            end
            else
            begin
                rsp_t want;
                want = pending_rsp.pop_front();
                if (result.probe_count !== want.probe_count)
                    report("probe_count", want.probe_count, result.probe_count);
                if (result.status !== want.status)
                    report("status", want.status, result.status);
                if (result.collision_total !== want.collision_total)
                    report("collision_total", want.collision_total, result.collision_total);
                if (result.live_entries !== want.live_entries)
                    report("live_entries", want.live_entries, result.live_entries);
            end
        end
    end

    // Watchdog on cycles where no beat of any kind is taken.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        req_t r;
        int   pick;
        rsp_t none;
        none = '0;

        // Hand-checked rows first, then edge keys and a fill to capacity at size 13.
        dir_rows = '{
            '{CMD_INSERT, 31'd5, 32'd11, 1'b1, '{13'd1, STAT_INSERTED, 32'd0, 13'd1}},
            '{CMD_INSERT, 31'd5, 32'd12, 1'b1, '{13'd1, STAT_DUPLICATE, 32'd0, 13'd1}},
            '{CMD_SEARCH, 31'd5, 32'd0, 1'b1, '{13'd1, STAT_FOUND, 32'd0, 13'd1}},
            '{CMD_SEARCH, 31'd18, 32'd0, 1'b1, '{13'd2, STAT_ABSENT, 32'd0, 13'd1}},
            '{CMD_REMOVE, 31'd5, 32'd0, 1'b1, '{13'd1, STAT_REMOVED, 32'd0, 13'd0}},
            '{CMD_REMOVE, 31'd5, 32'd0, 1'b1, '{13'd2, STAT_REMOVE_MISS, 32'd0, 13'd0}},
            '{CMD_ALT_SEARCH, 31'd5, 32'd0, 1'b1, '{13'd2, STAT_ABSENT, 32'd0, 13'd0}},
            '{CMD_INSERT, 31'd18, 32'd7, 1'b1, '{13'd1, STAT_INSERTED, 32'd0, 13'd1}},
            '{CMD_INSERT, 31'd0, 32'h8000_0000, 1'b0, none},
            '{CMD_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, none},
            '{CMD_INSERT, 31'd200, 32'hFFFF_FFFF, 1'b0, none},
            '{CMD_INSERT, 31'd201, 32'd1, 1'b0, none},
            '{CMD_INSERT, 31'd202, 32'd2, 1'b0, none},
            '{CMD_INSERT, 31'd203, 32'd3, 1'b0, none},
            '{CMD_INSERT, 31'd204, 32'd4, 1'b0, none},
            '{CMD_INSERT, 31'd205, 32'd5, 1'b0, none},
            '{CMD_INSERT, 31'd206, 32'd6, 1'b0, none},
            '{CMD_INSERT, 31'd207, 32'd7, 1'b0, none},
            '{CMD_INSERT, 31'd208, 32'd8, 1'b0, none},
            '{CMD_INSERT, 31'd209, 32'd9, 1'b0, none},
            '{CMD_INSERT, 31'd300, 32'd0, 1'b0, none},
            '{CMD_SEARCH, 31'd300, 32'd0, 1'b0, none},
            '{CMD_REMOVE, 31'd300, 32'd0, 1'b0, none}
        };

        // Settings walked by the random part; sizes 0, 8191 and 5000 exercise clamping.
        phases = '{
            '{1'b0, 1'b0, 16'd1, 16'd1, 13'd13, 30},
            '{1'b1, 1'b0, 16'd1, 16'd1, 13'd17, 50},
            '{1'b0, 1'b1, 16'd1, 16'd1, 13'd31, 50},
            '{1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 13'd61, 50},
            '{1'b0, 1'b1, 16'd0, 16'd0, 13'd13, 20},
            '{1'b1, 1'b1, 16'd0, 16'hFFFF, 13'd31, 40},
            '{1'b0, 1'b0, 16'd1, 16'd1, 13'd0, 40},
            '{1'b1, 1'b0, 16'd1, 16'd1, 13'h1FFF, 30},
            '{1'b0, 1'b1, 16'd7, 16'd3, 13'd4096, 30},
            '{1'b1, 1'b0, 16'd1, 16'd1, 13'd5000, 20},
            '{1'b0, 1'b0, 16'd1, 16'd1, 13'd23, 60},
            '{1'b1, 1'b1, 16'd0, 16'd0, 13'd97, 60},
            '{1'b0, 1'b0, 16'd1, 16'd1, 13'd13, 60}
        };
        phases[11].c1 = 16'($urandom);
        phases[11].c2 = 16'($urandom);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part runs on the reset configuration.
        foreach (dir_rows[n])
        begin
            r.command = dir_rows[n].cmd;
            r.key = dir_rows[n].key;
            r.payload = dir_rows[n].pay;
            send_cmd(r, dir_rows[n].typed, dir_rows[n].rsp);
        end

        // Random phases; the table is left populated across size changes on purpose.
        foreach (phases[p])
        begin
            write_reg(REG_HASH_SELECT, {31'd0, phases[p].hs});
            write_reg(REG_PROBE_MODE, {31'd0, phases[p].pm});
            write_reg(REG_COEF_ONE, {16'd0, phases[p].c1});
            write_reg(REG_COEF_TWO, {16'd0, phases[p].c2});
            write_reg(REG_TABLE_SIZE, {19'd0, phases[p].size});
            foreach (key_pool[k])
                key_pool[k] = ($urandom_range(0, 1) != 0) ? 31'($urandom_range(0, 200))
                                                           : 31'($urandom);
            for (int n = 0; n < phases[p].count; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40) r.command = CMD_INSERT;
                else if (pick < 70) r.command = CMD_SEARCH;
                else if (pick < 95) r.command = CMD_REMOVE;
                else r.command = CMD_ALT_SEARCH;
                if ($urandom_range(0, 9) < 7)
                    r.key = key_pool[$urandom_range(0, 15)];
                else
                    r.key = 31'($urandom);
                r.payload = $urandom;
                send_cmd(r, 1'b0, none);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- open_address_hash_table.f -----
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_rem.sv
hw/rtl/oaht_slot_mem.sv
hw/rtl/open_address_hash_table.sv
tb/tb_open_address_hash_table.sv
